>>> hdl/pdq_pkg.sv
`timescale 1ns / 1ps

package pdq_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned IdxW     = $clog2(Capacity);

  localparam logic [3:0] ActInsHead = 4'd0;
  localparam logic [3:0] ActInsTail = 4'd1;
  localparam logic [3:0] ActRemHead = 4'd2;
  localparam logic [3:0] ActRemTail = 4'd3;
  localparam logic [3:0] ActRdHead  = 4'd4;
  localparam logic [3:0] ActRdTail  = 4'd5;
  localparam logic [3:0] ActRdIndex = 4'd6;
  localparam logic [3:0] ActContain = 4'd7;
  localparam logic [3:0] ActClear   = 4'd8;

  typedef struct packed {
    logic [7:0] sym;
    logic [7:0] y;
    logic [7:0] x;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic shift_up;
    logic shift_down;
  } cell_ctrl_t;

endpackage

>>> hdl/position_deque_with_search.sv
`timescale 1ns / 1ps

// Bounded ordered list of up to 64 (x, y, symbol) entries held in a row of
// register cells, with the head in cell zero. On acceptance every cell shifts
// or loads in parallel and compares its entry against the search key, while
// the entry chosen by the cell read multiplexer is captured. Then, as soon as
// the output register is free, the match flags and the captured entry form
// the result. A new transaction is taken once the previous result has moved
// into the output register; until then s_axis_tready stays low.
// Inserts into a full list and removals from an empty list are ignored, and
// reads that miss return zeros; every result carries the count of entries.
module position_deque_with_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x[7:0], pos_y[15:8], pos_symbol[23:16], slot[29:24], zero pad.
  input  logic [31:0] s_axis_tdata,
  // action[3:0].
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_x[7:0], out_y[15:8], out_symbol[23:16], found[24], fill_count[31:25].
  output logic [31:0] m_axis_tdata
);

  localparam logic StIdle = 1'b0;
  localparam logic StEval = 1'b1;

  logic state_q, state_d;
  logic [pdq_pkg::CntW-1:0] count_q, count_d;
  logic out_valid_q, out_valid_d;
  logic [31:0] out_data_q, out_data_d;
  pdq_pkg::entry_t rd_q, rd_d;
  logic rd_hit_q, rd_hit_d;
  logic find_q, find_d;

  pdq_pkg::entry_t new_entry;
  logic [5:0] slot;
  logic [3:0] action;
  logic accept;
  logic not_full, not_empty;
  pdq_pkg::cell_ctrl_t ctrl;
  logic ins_tail;
  logic [pdq_pkg::IdxW-1:0] rd_addr;

  pdq_pkg::entry_t entries [pdq_pkg::Capacity];
  logic [pdq_pkg::Capacity-1:0] match;

  assign new_entry.x   = s_axis_tdata[7:0];
  assign new_entry.y   = s_axis_tdata[15:8];
  assign new_entry.sym = s_axis_tdata[23:16];
  assign slot          = s_axis_tdata[29:24];
  assign action        = s_axis_tuser;

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign not_full      = (count_q < pdq_pkg::CntW'(pdq_pkg::Capacity));
  assign not_empty     = (count_q != '0);

  always_comb begin
    ctrl.capture    = accept;
    ctrl.shift_up   = (action == pdq_pkg::ActInsHead) && not_full;
    ctrl.shift_down = (action == pdq_pkg::ActRemHead) && not_empty;
    ins_tail        = (action == pdq_pkg::ActInsTail) && not_full;
  end

  for (genvar k = 0; k < pdq_pkg::Capacity; k++) begin : g_cell
    pdq_pkg::entry_t prev_e, next_e;
    if (k == 0) begin : g_first
      assign prev_e = new_entry;
    end else begin : g_mid_prev
      assign prev_e = entries[k-1];
    end
    if (k == pdq_pkg::Capacity - 1) begin : g_last
      assign next_e = entries[k];
    end else begin : g_mid_next
      assign next_e = entries[k+1];
    end
    pdq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .load_i  (ins_tail && (count_q == pdq_pkg::CntW'(k))),
      .live_i  (pdq_pkg::CntW'(k) < count_q),
      .new_i   (new_entry),
      .prev_i  (prev_e),
      .next_i  (next_e),
      .entry_o (entries[k]),
      .match_o (match[k])
    );
  end

  always_comb begin
    count_d  = count_q;
    rd_addr  = '0;
    rd_hit_d = 1'b0;
    find_d   = 1'b0;
    unique case (action) inside
      pdq_pkg::ActInsHead, pdq_pkg::ActInsTail: begin
        if (not_full) count_d = count_q + 1'b1;
      end
      pdq_pkg::ActRemHead, pdq_pkg::ActRemTail: begin
        if (not_empty) count_d = count_q - 1'b1;
      end
      pdq_pkg::ActRdHead: begin
        rd_hit_d = not_empty;
      end
      pdq_pkg::ActRdTail: begin
        rd_addr  = pdq_pkg::IdxW'(count_q - 1'b1);
        rd_hit_d = not_empty;
      end
      pdq_pkg::ActRdIndex: begin
        rd_addr  = pdq_pkg::IdxW'(slot);
        rd_hit_d = (pdq_pkg::CntW'(slot) < count_q);
      end
      pdq_pkg::ActContain: begin
        find_d = 1'b1;
      end
      pdq_pkg::ActClear: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
    rd_d = entries[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q     <= rd_d;
      rd_hit_q <= rd_hit_d;
      find_q   <= find_d;
    end
    out_data_q <= out_data_d;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) state_d = StEval;
      end
      StEval: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {7'(count_q), find_q && (|match),
                         rd_hit_q ? rd_q : pdq_pkg::entry_t'('0)};
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) count_q <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> hdl/pdq_cell.sv
`timescale 1ns / 1ps

module pdq_cell (
  input  logic               clk_i,
  input  pdq_pkg::cell_ctrl_t ctrl_i,
  input  logic               load_i,
  input  logic               live_i,
  input  pdq_pkg::entry_t    new_i,
  input  pdq_pkg::entry_t    prev_i,
  input  pdq_pkg::entry_t    next_i,
  output pdq_pkg::entry_t    entry_o,
  output logic               match_o
);

  pdq_pkg::entry_t entry_q, entry_d;
  logic            match_q, match_d;

  always_comb begin
    entry_d = entry_q;
    match_d = match_q;
    if (ctrl_i.capture) begin
      match_d = live_i && (entry_q.x == new_i.x) && (entry_q.y == new_i.y);
      if (ctrl_i.shift_up) begin
        entry_d = prev_i;
      end else if (ctrl_i.shift_down) begin
        entry_d = next_i;
      end else if (load_i) begin
        entry_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

>>> dv/position_deque_with_search_tb.sv
`timescale 1ns / 1ps

module position_deque_with_search_tb;

  localparam logic [3:0]  ActFirstUndef = 4'd9;
  localparam logic [3:0]  ActLastUndef  = 4'd15;
  localparam int unsigned RandomItems   = 1700;
  localparam int unsigned QuietItems    = 300;
  localparam int unsigned CycleLimit    = 500000;
  localparam int unsigned DrainCycles   = 16;

  typedef enum int {ModeFill, ModeDrain, ModeMixed, ModeNoise} traffic_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  pdq_pkg::entry_t list_model[$];
  logic [31:0]     pending_results[$];
  logic [31:0]     expected_word;
  int unsigned     error_count = 0;
  int unsigned     cycle_count = 0;
  logic            idle_en = 1'b1;

  position_deque_with_search i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [31:0] apply_action(logic [3:0] act, logic [7:0] x, logic [7:0] y,
                                               logic [7:0] sym, logic [5:0] slot);
    pdq_pkg::entry_t          read_entry;
    pdq_pkg::entry_t          new_entry;
    logic                     hit;
    logic [pdq_pkg::CntW-1:0] count;
    read_entry = '0;
    new_entry  = pdq_pkg::entry_t'{sym, y, x};
    hit = 1'b0;
    case (act)
      pdq_pkg::ActInsHead: begin
        if (list_model.size() < pdq_pkg::Capacity) list_model.push_front(new_entry);
      end
      pdq_pkg::ActInsTail: begin
        if (list_model.size() < pdq_pkg::Capacity) list_model.push_back(new_entry);
      end
      pdq_pkg::ActRemHead: if (list_model.size() > 0) void'(list_model.pop_front());
      pdq_pkg::ActRemTail: if (list_model.size() > 0) void'(list_model.pop_back());
      pdq_pkg::ActRdHead:  if (list_model.size() > 0) read_entry = list_model[0];
      pdq_pkg::ActRdTail: begin
        if (list_model.size() > 0) read_entry = list_model[list_model.size() - 1];
      end
      pdq_pkg::ActRdIndex: if (slot < list_model.size()) read_entry = list_model[slot];
      pdq_pkg::ActContain: begin
        foreach (list_model[i]) begin
          if (list_model[i].x == x && list_model[i].y == y) hit = 1'b1;
        end
      end
      pdq_pkg::ActClear:   list_model.delete();
      default:             ;
    endcase
    count = pdq_pkg::CntW'(list_model.size());
    return {count, hit, read_entry};
  endfunction

  task automatic send_action(logic [3:0] act, logic [7:0] x, logic [7:0] y, logic [7:0] sym,
                             logic [5:0] slot);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, slot, sym, y, x};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_action(act, x, y, sym, slot));
  endtask

  task automatic check_field(string name, logic [7:0] expected, logic [7:0] actual);
    if (expected !== actual) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("Unexpected result transaction: tdata %h", m_axis_tdata);
        error_count++;
      end else begin
        expected_word = pending_results.pop_front();
        check_field("out_x", expected_word[7:0], m_axis_tdata[7:0]);
        check_field("out_y", expected_word[15:8], m_axis_tdata[15:8]);
        check_field("out_symbol", expected_word[23:16], m_axis_tdata[23:16]);
        check_field("found", {7'd0, expected_word[24]}, {7'd0, m_axis_tdata[24]});
        check_field("fill_count", {1'b0, expected_word[31:25]}, {1'b0, m_axis_tdata[31:25]});
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (idle_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_empty_list();
    send_action(pdq_pkg::ActRdHead, 8'h00, 8'h00, 8'h00, 6'd0);
    send_action(pdq_pkg::ActRdTail, 8'hff, 8'hff, 8'hff, 6'd63);
    send_action(pdq_pkg::ActRdIndex, 8'h00, 8'h00, 8'h00, 6'd0);
    send_action(pdq_pkg::ActContain, 8'h00, 8'h00, 8'h00, 6'd0);
    send_action(pdq_pkg::ActRemHead, 8'h00, 8'h00, 8'h00, 6'd0);
    send_action(pdq_pkg::ActRemTail, 8'hff, 8'hff, 8'hff, 6'd63);
  endtask

  task automatic test_insert_and_read();
    send_action(pdq_pkg::ActInsHead, 8'hff, 8'hff, 8'hff, 6'd63);
    send_action(pdq_pkg::ActInsTail, 8'h00, 8'h00, 8'h00, 6'd0);
    send_action(pdq_pkg::ActInsHead, 8'h5a, 8'ha5, 8'h3c, 6'd21);
    send_action(pdq_pkg::ActRdHead, 8'h00, 8'h00, 8'h00, 6'd0);
    send_action(pdq_pkg::ActRdTail, 8'h00, 8'h00, 8'h00, 6'd0);
    send_action(pdq_pkg::ActRdIndex, 8'h00, 8'h00, 8'h00, 6'd1);
    send_action(pdq_pkg::ActRdIndex, 8'h00, 8'h00, 8'h00, 6'd63);
    send_action(pdq_pkg::ActRdIndex, 8'h00, 8'h00, 8'h00, 6'd3);
  endtask

  task automatic test_search();
    send_action(pdq_pkg::ActContain, 8'hff, 8'hff, 8'h00, 6'd0);
    send_action(pdq_pkg::ActContain, 8'hff, 8'h00, 8'hff, 6'd0);
    send_action(pdq_pkg::ActContain, 8'h5a, 8'ha5, 8'hc3, 6'd42);
  endtask

  task automatic test_undefined_actions();
    send_action(ActFirstUndef, 8'hff, 8'hff, 8'hff, 6'd63);
    send_action(ActLastUndef, 8'hff, 8'hff, 8'hff, 6'd0);
  endtask

  task automatic test_remove_and_clear();
    send_action(pdq_pkg::ActRemHead, 8'h00, 8'h00, 8'h00, 6'd0);
    send_action(pdq_pkg::ActRemTail, 8'h00, 8'h00, 8'h00, 6'd0);
    send_action(pdq_pkg::ActRdHead, 8'h00, 8'h00, 8'h00, 6'd0);
    send_action(pdq_pkg::ActClear, 8'hff, 8'hff, 8'hff, 6'd63);
    send_action(pdq_pkg::ActRdTail, 8'h00, 8'h00, 8'h00, 6'd0);
  endtask

  // Runs of biased traffic push the list to full and back to empty, with
  // reads and searches aimed mostly at live entries.
  task automatic test_random_traffic();
    int unsigned     issued;
    int unsigned     run_len;
    int unsigned     roll;
    traffic_mode_e   mode;
    logic [3:0]      act;
    logic [7:0]      x;
    logic [7:0]      y;
    logic [7:0]      sym;
    logic [5:0]      slot;
    pdq_pkg::entry_t pick;
    issued = 0;
    while (issued < RandomItems) begin
      mode = traffic_mode_e'($urandom_range(0, 3));
      run_len = $urandom_range(20, 90);
      repeat (run_len) begin
        if (issued >= RandomItems - QuietItems) idle_en = 1'b0;
        roll = $urandom_range(0, 99);
        case (mode)
          ModeFill: begin
            if (roll < 70) begin
              act = $urandom_range(0, 1) ? pdq_pkg::ActInsHead : pdq_pkg::ActInsTail;
            end else if (roll < 80) begin
              act = $urandom_range(0, 1) ? pdq_pkg::ActRemHead : pdq_pkg::ActRemTail;
            end else begin
              act = 4'($urandom_range(pdq_pkg::ActRdHead, pdq_pkg::ActContain));
            end
          end
          ModeDrain: begin
            if (roll == 99) begin
              act = pdq_pkg::ActClear;
            end else if (roll < 65) begin
              act = $urandom_range(0, 1) ? pdq_pkg::ActRemHead : pdq_pkg::ActRemTail;
            end else if (roll < 75) begin
              act = $urandom_range(0, 1) ? pdq_pkg::ActInsHead : pdq_pkg::ActInsTail;
            end else begin
              act = 4'($urandom_range(pdq_pkg::ActRdHead, pdq_pkg::ActContain));
            end
          end
          ModeMixed: begin
            if (roll < 2) act = pdq_pkg::ActClear;
            else act = 4'($urandom_range(pdq_pkg::ActInsHead, pdq_pkg::ActContain));
          end
          default: act = 4'($urandom_range(0, 15));
        endcase
        x    = 8'($urandom_range(0, 255));
        y    = 8'($urandom_range(0, 255));
        sym  = 8'($urandom_range(0, 255));
        slot = 6'($urandom_range(0, 63));
        if (mode != ModeNoise && list_model.size() > 0) begin
          if (act == pdq_pkg::ActContain && $urandom_range(0, 3) != 0) begin
            pick = list_model[$urandom_range(0, list_model.size() - 1)];
            x = pick.x;
            y = ($urandom_range(0, 4) == 0) ? pick.y ^ 8'(1 << $urandom_range(0, 7)) : pick.y;
          end
          if (act == pdq_pkg::ActRdIndex && $urandom_range(0, 3) != 0) begin
            slot = 6'($urandom_range(0, list_model.size() - 1));
          end
        end
        send_action(act, x, y, sym, slot);
        issued++;
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_insert_and_read();
    test_search();
    test_undefined_actions();
    test_remove_and_clear();
    test_random_traffic();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
